// ----- rtl/ast_pkg.sv -----
package ast_pkg;

  // Line counter width; line_no carries its low 16 bits
  localparam int LINE_BITS  = 16;
  localparam int LINE_NO_W  = 16;

  // Result queue geometry
  localparam int MAX_RES    = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Character codes
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NL         = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_QUOTE      = 8'h27;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_BSLASH     = 8'h5C;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOW_N      = 8'h6E;
  localparam logic [7:0] CH_LOW_T      = 8'h74;
  localparam logic [7:0] CH_PRINT_LO   = 8'h21;
  localparam logic [7:0] CH_PRINT_HI   = 8'h7E;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_STR0,
    MODE_STRH,
    MODE_STRESC0,
    MODE_STRESCH,
    MODE_CHR,
    MODE_CHRESC,
    MODE_CHRCLOSE
  } mode_e;

  typedef enum logic [1:0] {
    KIND_PUNCT,
    KIND_NUMBER,
    KIND_IDENT,
    KIND_STRING
  } kind_e;

  typedef struct packed {
    logic [7:0]           tok_char;
    logic                 has_char;
    kind_e                token_kind;
    logic                 begins;
    logic                 closes;
    logic [LINE_NO_W-1:0] line_no;
    logic                 last_result;
  } res_t;

  // Results produced by one accepted item
  typedef struct packed {
    logic [1:0]              count;
    res_t [MAX_RES-1:0]      ent;
  } push_t;

  typedef struct packed {
    logic [FIFO_AW:0] used;
  } fifo_stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // String escape: n and t map, anything else is itself
  function automatic logic [7:0] esc_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == CH_LOW_N) r = CH_NL;
    else if (c == CH_LOW_T) r = CH_TAB;
    return r;
  endfunction

  function automatic res_t mk_res(input logic [7:0] c, input logic has, input kind_e kind,
                                  input logic beg, input logic cls,
                                  input logic [LINE_NO_W-1:0] line);
    res_t r;
    r.tok_char    = c;
    r.has_char    = has;
    r.token_kind  = kind;
    r.begins      = beg;
    r.closes      = cls;
    r.line_no     = line;
    r.last_result = 1'b0;
    return r;
  endfunction

  // Decimal digits of a byte: {hundreds, tens, ones}, 4 bits each.
  // Tens by reciprocal multiply, exact for values below 100.
  function automatic logic [11:0] dec_digits(input logic [7:0] v);
    logic [1:0]  h;
    logic [6:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = 7'(v - 8'(h) * 8'd100);
    p = 15'(r) * 15'd205;
    t = p[14:11];
    o = r - 7'(t) * 7'd10;
    return {2'b00, h, t, o[3:0]};
  endfunction

endpackage

// ----- rtl/ast_scan.sv -----
module ast_scan (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      ch_i,
  input  logic            eos_i,
  output ast_pkg::push_t  push_o
);

  ast_pkg::mode_e                  mode_q, mode_d;
  logic [ast_pkg::LINE_BITS-1:0]   line_q, line_d;
  logic [7:0]                      held_q, held_d;
  logic                            first_q, first_d;

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ast_pkg::MODE_IDLE;
      line_q  <= ast_pkg::LINE_BITS'(1);
      held_q  <= '0;
      first_q <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      held_q  <= held_d;
      first_q <= first_d;
    end
  end

  logic [ast_pkg::LINE_NO_W-1:0] line_no;
  assign line_no = ast_pkg::LINE_NO_W'(line_q);

  logic [11:0] digits;
  assign digits = ast_pkg::dec_digits(held_q);

  // Next state and result items for the item at the input
  always_comb begin
    logic [1:0]      n;
    logic            run_idle;
    logic            more;
    ast_pkg::kind_e  kind;
    ast_pkg::res_t [ast_pkg::MAX_RES-1:0] ent;

    n        = 2'd0;
    run_idle = 1'b0;
    more     = 1'b0;
    kind     = (mode_q == ast_pkg::MODE_NUMBER) ? ast_pkg::KIND_NUMBER : ast_pkg::KIND_IDENT;
    ent      = '0;
    mode_d   = mode_q;
    line_d   = line_q;
    held_d   = held_q;
    first_d  = first_q;

    if (eos_i) begin
      // close whatever is open, then back to reset state
      case (mode_q)
        ast_pkg::MODE_NUMBER, ast_pkg::MODE_IDENT: begin
          ent[n] = ast_pkg::mk_res(held_q, 1'b1, kind, first_q, 1'b1, line_no);
          n = n + 2'd1;
        end
        ast_pkg::MODE_STRH, ast_pkg::MODE_STRESCH: begin
          ent[n] = ast_pkg::mk_res(held_q, 1'b1, ast_pkg::KIND_STRING, first_q, 1'b1, line_no);
          n = n + 2'd1;
        end
        ast_pkg::MODE_STR0, ast_pkg::MODE_STRESC0: begin
          ent[n] = ast_pkg::mk_res(8'h00, 1'b0, ast_pkg::KIND_STRING, 1'b1, 1'b1, line_no);
          n = n + 2'd1;
        end
        ast_pkg::MODE_CHRCLOSE: begin
          if (digits[9:8] != 2'd0) begin
            ent[n] = ast_pkg::mk_res(ast_pkg::CH_ZERO + 8'(digits[11:8]), 1'b1,
                                     ast_pkg::KIND_NUMBER, 1'b1, 1'b0, line_no);
            n = n + 2'd1;
            ent[n] = ast_pkg::mk_res(ast_pkg::CH_ZERO + 8'(digits[7:4]), 1'b1,
                                     ast_pkg::KIND_NUMBER, 1'b0, 1'b0, line_no);
            n = n + 2'd1;
          end else if (digits[7:4] != 4'd0) begin
            ent[n] = ast_pkg::mk_res(ast_pkg::CH_ZERO + 8'(digits[7:4]), 1'b1,
                                     ast_pkg::KIND_NUMBER, 1'b1, 1'b0, line_no);
            n = n + 2'd1;
          end
          ent[n] = ast_pkg::mk_res(ast_pkg::CH_ZERO + 8'(digits[3:0]), 1'b1,
                                   ast_pkg::KIND_NUMBER, (held_q < 8'd10), 1'b1, line_no);
          n = n + 2'd1;
        end
        default: ;
      endcase
      mode_d  = ast_pkg::MODE_IDLE;
      line_d  = ast_pkg::LINE_BITS'(1);
      held_d  = '0;
      first_d = 1'b0;
    end else begin
      case (mode_q)
        ast_pkg::MODE_NUMBER, ast_pkg::MODE_IDENT: begin
          more = ast_pkg::is_digit(ch_i) || ast_pkg::is_alpha(ch_i) ||
                 ((mode_q == ast_pkg::MODE_IDENT) && (ch_i == ast_pkg::CH_UNDERSCORE));
          ent[n] = ast_pkg::mk_res(held_q, 1'b1, kind, first_q, !more, line_no);
          n = n + 2'd1;
          if (more) begin
            held_d  = ch_i;
            first_d = 1'b0;
          end else begin
            run_idle = 1'b1;
          end
        end
        ast_pkg::MODE_COMMENT: begin
          if (ch_i == ast_pkg::CH_NL) run_idle = 1'b1;
        end
        ast_pkg::MODE_STR0: begin
          if (ch_i == ast_pkg::CH_DQUOTE) begin
            ent[n] = ast_pkg::mk_res(8'h00, 1'b0, ast_pkg::KIND_STRING, 1'b1, 1'b1, line_no);
            n = n + 2'd1;
            mode_d = ast_pkg::MODE_IDLE;
          end else if (ch_i == ast_pkg::CH_BSLASH) begin
            mode_d = ast_pkg::MODE_STRESC0;
          end else begin
            held_d  = ch_i;
            first_d = 1'b1;
            mode_d  = ast_pkg::MODE_STRH;
          end
        end
        ast_pkg::MODE_STRH: begin
          if (ch_i == ast_pkg::CH_DQUOTE) begin
            ent[n] = ast_pkg::mk_res(held_q, 1'b1, ast_pkg::KIND_STRING, first_q, 1'b1, line_no);
            n = n + 2'd1;
            mode_d = ast_pkg::MODE_IDLE;
          end else if (ch_i == ast_pkg::CH_BSLASH) begin
            mode_d = ast_pkg::MODE_STRESCH;
          end else begin
            ent[n] = ast_pkg::mk_res(held_q, 1'b1, ast_pkg::KIND_STRING, first_q, 1'b0, line_no);
            n = n + 2'd1;
            held_d  = ch_i;
            first_d = 1'b0;
          end
        end
        ast_pkg::MODE_STRESC0: begin
          held_d  = ast_pkg::esc_char(ch_i);
          first_d = 1'b1;
          mode_d  = ast_pkg::MODE_STRH;
        end
        ast_pkg::MODE_STRESCH: begin
          ent[n] = ast_pkg::mk_res(held_q, 1'b1, ast_pkg::KIND_STRING, first_q, 1'b0, line_no);
          n = n + 2'd1;
          held_d  = ast_pkg::esc_char(ch_i);
          first_d = 1'b0;
          mode_d  = ast_pkg::MODE_STRH;
        end
        ast_pkg::MODE_CHR: begin
          if (ch_i == ast_pkg::CH_BSLASH) begin
            mode_d = ast_pkg::MODE_CHRESC;
          end else begin
            held_d = ch_i;
            mode_d = ast_pkg::MODE_CHRCLOSE;
          end
        end
        ast_pkg::MODE_CHRESC: begin
          if (ch_i == ast_pkg::CH_BSLASH) held_d = ast_pkg::CH_BSLASH;
          else if (ch_i == ast_pkg::CH_LOW_T) held_d = ast_pkg::CH_TAB;
          else if (ch_i == ast_pkg::CH_LOW_N) held_d = ast_pkg::CH_NL;
          else held_d = 8'h00;
          mode_d = ast_pkg::MODE_CHRCLOSE;
        end
        ast_pkg::MODE_CHRCLOSE: begin
          // closing byte is not checked; send the decimal code
          if (digits[9:8] != 2'd0) begin
            ent[n] = ast_pkg::mk_res(ast_pkg::CH_ZERO + 8'(digits[11:8]), 1'b1,
                                     ast_pkg::KIND_NUMBER, 1'b1, 1'b0, line_no);
            n = n + 2'd1;
            ent[n] = ast_pkg::mk_res(ast_pkg::CH_ZERO + 8'(digits[7:4]), 1'b1,
                                     ast_pkg::KIND_NUMBER, 1'b0, 1'b0, line_no);
            n = n + 2'd1;
          end else if (digits[7:4] != 4'd0) begin
            ent[n] = ast_pkg::mk_res(ast_pkg::CH_ZERO + 8'(digits[7:4]), 1'b1,
                                     ast_pkg::KIND_NUMBER, 1'b1, 1'b0, line_no);
            n = n + 2'd1;
          end
          ent[n] = ast_pkg::mk_res(ast_pkg::CH_ZERO + 8'(digits[3:0]), 1'b1,
                                   ast_pkg::KIND_NUMBER, (held_q < 8'd10), 1'b1, line_no);
          n = n + 2'd1;
          mode_d = ast_pkg::MODE_IDLE;
        end
        default: run_idle = 1'b1;
      endcase

      // idle handling, also for the byte that ends a number or identifier
      if (run_idle) begin
        mode_d = ast_pkg::MODE_IDLE;
        if (ch_i == ast_pkg::CH_NL) begin
          if (line_q != '1) line_d = line_q + ast_pkg::LINE_BITS'(1);
        end else if ((ch_i == ast_pkg::CH_SPACE) || (ch_i == ast_pkg::CH_TAB)) begin
          mode_d = ast_pkg::MODE_IDLE;
        end else if (ch_i == ast_pkg::CH_SEMI) begin
          mode_d = ast_pkg::MODE_COMMENT;
        end else if (ch_i == ast_pkg::CH_QUOTE) begin
          mode_d = ast_pkg::MODE_CHR;
        end else if (ch_i == ast_pkg::CH_DQUOTE) begin
          mode_d = ast_pkg::MODE_STR0;
        end else if (ast_pkg::is_digit(ch_i)) begin
          held_d  = ch_i;
          first_d = 1'b1;
          mode_d  = ast_pkg::MODE_NUMBER;
        end else if (ast_pkg::is_alpha(ch_i) || (ch_i == ast_pkg::CH_UNDERSCORE)) begin
          held_d  = ch_i;
          first_d = 1'b1;
          mode_d  = ast_pkg::MODE_IDENT;
        end else if ((ch_i >= ast_pkg::CH_PRINT_LO) && (ch_i <= ast_pkg::CH_PRINT_HI)) begin
          ent[n] = ast_pkg::mk_res(ch_i, 1'b1, ast_pkg::KIND_PUNCT, 1'b1, 1'b1, line_no);
          n = n + 2'd1;
        end
      end
    end

    // mark the final result of this item
    if (n != 2'd0) ent[n - 2'd1].last_result = 1'b1;

    push_o.ent   = ent;
    push_o.count = accept_i ? n : 2'd0;
  end

endmodule

// ----- rtl/ast_fifo.sv -----
module ast_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ast_pkg::push_t       push_i,
  input  logic                 pop_i,
  output ast_pkg::res_t        head_o,
  output ast_pkg::fifo_stat_t  stat_o
);

  ast_pkg::res_t             mem_q [ast_pkg::FIFO_DEPTH];
  logic [ast_pkg::FIFO_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [ast_pkg::FIFO_AW:0]   used_q, used_d;

  // Pointers and fill level
  always_comb begin
    wr_d   = wr_q + ast_pkg::FIFO_AW'(push_i.count);
    rd_d   = rd_q + ast_pkg::FIFO_AW'(pop_i);
    used_d = used_q + (ast_pkg::FIFO_AW + 1)'(push_i.count)
                    - (ast_pkg::FIFO_AW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      used_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      used_q <= used_d;
    end
  end

  // Entry storage: up to three writes per cycle at consecutive slots
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ast_pkg::MAX_RES; i++) begin
      if (2'(i) < push_i.count) begin
        mem_q[wr_q + ast_pkg::FIFO_AW'(i)] <= push_i.ent[i];
      end
    end
  end

  assign head_o      = mem_q[rd_q];
  assign stat_o.used = used_q;

endmodule

// ----- rtl/assembly_source_tokenizer_unit.sv -----
// Assembly source tokenizer: takes one source byte per cycle while ready and emits
// token characters with kind, begin/close flags and line number. Each byte is
// scanned in the cycle it is accepted and gives zero to three result items,
// which enter an 8-entry result queue; the output side delivers one item per
// cycle from that queue while m_axis_tready is high. The input takes a byte
// whenever at least three queue entries are free, so with a draining output the
// block sustains one byte per cycle; a character literal closing with a
// three-digit code is the only case that produces three items. Result items
// are written into the queue at the clock edge that accepts the byte.
module assembly_source_tokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,   // end_of_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] tok_char, [23:8] line_no
  output logic [4:0]  m_axis_tuser,   // [0] has_char, [2:1] token_kind, [3] begins, [4] closes
  output logic        m_axis_tlast    // last_result
);

  logic                 s_accept;
  logic                 m_pop;
  ast_pkg::push_t       push;
  ast_pkg::res_t        head;
  ast_pkg::fifo_stat_t  stat;

  // Accept only with room for the worst-case burst
  assign s_axis_tready = (stat.used <=
                          (ast_pkg::FIFO_AW + 1)'(ast_pkg::FIFO_DEPTH - ast_pkg::MAX_RES));
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (stat.used != '0);
  assign m_pop         = m_axis_tvalid && m_axis_tready;

  ast_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_accept),
    .ch_i     (s_axis_tdata),
    .eos_i    (s_axis_tlast),
    .push_o   (push)
  );

  ast_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (m_pop),
    .head_o (head),
    .stat_o (stat)
  );

  // Output packing
  assign m_axis_tdata = {head.line_no, head.tok_char};
  assign m_axis_tuser = {head.closes, head.begins, head.token_kind, head.has_char};
  assign m_axis_tlast = head.last_result;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.used <= (ast_pkg::FIFO_AW + 1)'(ast_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_no_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_accept |-> (push.count == 2'd0))
    else $error("results pushed without an accepted item");

  a_fill_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (stat.used == $past(stat.used) + (ast_pkg::FIFO_AW + 1)'($past(push.count))
                           - (ast_pkg::FIFO_AW + 1)'($past(m_pop))))
    else $error("queue fill level out of step");

  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.count != 2'd0) |-> push.ent[push.count - 2'd1].last_result)
    else $error("final result of an item not marked last");

endmodule

// ----- sim/tb_assembly_source_tokenizer_unit.sv -----
module tb_assembly_source_tokenizer_unit;
  import ast_pkg::*;

  // Directed row checking: by predictor, no item, or one typed item
  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_QUIET,
    ROW_TYPED
  } row_check_e;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
    row_check_e chk;
    res_t       want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] ch
  logic        s_axis_tlast;   // end_of_source
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] tok_char, [23:8] line_no
  logic [4:0]  m_axis_tuser;   // [0] has_char, [2:1] token_kind, [3] begins, [4] closes
  logic        m_axis_tlast;   // last_result

  assembly_source_tokenizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Scanner copy kept by the testbench
  mode_e                scan_st;
  logic [LINE_BITS-1:0] line_cnt;
  logic [7:0]           held_ch;
  logic                 held_first;
  res_t                 step_out[$];

  // Token items still to arrive, oldest first
  res_t     tokens_due[$];
  dir_row_t dir_rows[$];
  int       mismatch_cnt;
  int       rand_items;
  bit       tx_gaps;

  // Receiver pacing
  bit       hold_req;
  bit       hold_seen;
  int       hold_left;
  int       stall_left;
  int       calm_left;
  int       rx_roll;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic bit char_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit char_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void predict_reset();
    scan_st    = MODE_IDLE;
    line_cnt   = LINE_BITS'(1);
    held_ch    = 8'd0;
    held_first = 1'b0;
  endfunction

  function automatic void add_item(input logic [7:0] c, input logic has, input kind_e k,
                                   input logic beg, input logic cls);
    res_t r;
    r.tok_char    = c;
    r.has_char    = has;
    r.token_kind  = k;
    r.begins      = beg;
    r.closes      = cls;
    r.line_no     = line_cnt[LINE_NO_W-1:0];
    r.last_result = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void add_held(input kind_e k, input logic cls);
    add_item(held_ch, 1'b1, k, held_first, cls);
  endfunction

  // Character literal code as decimal digits, most significant first
  function automatic void add_code();
    int v;
    v = int'(held_ch);
    if (v >= 100) begin
      add_item(8'(48 + v / 100), 1'b1, KIND_NUMBER, 1'b1, 1'b0);
      add_item(8'(48 + (v / 10) % 10), 1'b1, KIND_NUMBER, 1'b0, 1'b0);
    end else if (v >= 10) begin
      add_item(8'(48 + v / 10), 1'b1, KIND_NUMBER, 1'b1, 1'b0);
    end
    add_item(8'(48 + v % 10), 1'b1, KIND_NUMBER, v < 10, 1'b1);
  endfunction

  // Byte seen while no token is open
  function automatic void idle_byte(input logic [7:0] c);
    scan_st = MODE_IDLE;
    if (c == CH_NL) begin
      if (line_cnt != {LINE_BITS{1'b1}}) line_cnt = line_cnt + 1'b1;
    end else if (c == CH_SPACE || c == CH_TAB) begin
    end else if (c == CH_SEMI) begin
      scan_st = MODE_COMMENT;
    end else if (c == CH_QUOTE) begin
      scan_st = MODE_CHR;
    end else if (c == CH_DQUOTE) begin
      scan_st = MODE_STR0;
    end else if (char_digit(c)) begin
      held_ch = c; held_first = 1'b1; scan_st = MODE_NUMBER;
    end else if (char_letter(c) || c == CH_UNDERSCORE) begin
      held_ch = c; held_first = 1'b1; scan_st = MODE_IDENT;
    end else if (c >= CH_PRINT_LO && c <= CH_PRINT_HI) begin
      add_item(c, 1'b1, KIND_PUNCT, 1'b1, 1'b1);
    end
  endfunction

  function automatic logic [7:0] str_escape(input logic [7:0] c);
    if (c == CH_LOW_N) return CH_NL;
    if (c == CH_LOW_T) return CH_TAB;
    return c;
  endfunction

  // Token items caused by one input byte, left in step_out
  function automatic void scan_byte(input logic [7:0] c, input logic eos);
    kind_e k;
    bit    more;
    step_out.delete();
    if (eos) begin
      case (scan_st)
        MODE_NUMBER:                  add_held(KIND_NUMBER, 1'b1);
        MODE_IDENT:                   add_held(KIND_IDENT, 1'b1);
        MODE_STRH, MODE_STRESCH:      add_held(KIND_STRING, 1'b1);
        MODE_STR0, MODE_STRESC0:      add_item(8'd0, 1'b0, KIND_STRING, 1'b1, 1'b1);
        MODE_CHRCLOSE:                add_code();
        default: ;
      endcase
      predict_reset();
    end else begin
      case (scan_st)
        MODE_NUMBER, MODE_IDENT: begin
          k = (scan_st == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
          more = char_digit(c) || char_letter(c) || (k == KIND_IDENT && c == CH_UNDERSCORE);
          if (more) begin
            add_held(k, 1'b0);
            held_ch = c; held_first = 1'b0;
          end else begin
            add_held(k, 1'b1);
            idle_byte(c);
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NL) idle_byte(c);
        end
        MODE_STR0: begin
          if (c == CH_DQUOTE) begin
            add_item(8'd0, 1'b0, KIND_STRING, 1'b1, 1'b1);
            scan_st = MODE_IDLE;
          end else if (c == CH_BSLASH) begin
            scan_st = MODE_STRESC0;
          end else begin
            held_ch = c; held_first = 1'b1; scan_st = MODE_STRH;
          end
        end
        MODE_STRH: begin
          if (c == CH_DQUOTE) begin
            add_held(KIND_STRING, 1'b1);
            scan_st = MODE_IDLE;
          end else if (c == CH_BSLASH) begin
            scan_st = MODE_STRESCH;
          end else begin
            add_held(KIND_STRING, 1'b0);
            held_ch = c; held_first = 1'b0;
          end
        end
        MODE_STRESC0: begin
          held_ch = str_escape(c); held_first = 1'b1; scan_st = MODE_STRH;
        end
        MODE_STRESCH: begin
          add_held(KIND_STRING, 1'b0);
          held_ch = str_escape(c); held_first = 1'b0; scan_st = MODE_STRH;
        end
        MODE_CHR: begin
          if (c == CH_BSLASH) begin
            scan_st = MODE_CHRESC;
          end else begin
            held_ch = c; scan_st = MODE_CHRCLOSE;
          end
        end
        MODE_CHRESC: begin
          // char literal escapes: backslash, tab, newline, anything else is zero
          if (c == CH_BSLASH) held_ch = CH_BSLASH;
          else if (c == CH_LOW_T) held_ch = CH_TAB;
          else if (c == CH_LOW_N) held_ch = CH_NL;
          else held_ch = 8'd0;
          scan_st = MODE_CHRCLOSE;
        end
        MODE_CHRCLOSE: begin
          add_code();
          scan_st = MODE_IDLE;
        end
        default: idle_byte(c);
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].last_result = 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one byte and wait for the handshake; updates the scanner copy
  task automatic send_byte(input logic [7:0] c, input logic eos);
    int unsigned g;
    g = tx_gaps ? pick_gap() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    scan_byte(c, eos);
    rand_items++;
  endtask

  task automatic send_pred(input logic [7:0] c, input logic eos);
    send_byte(c, eos);
    foreach (step_out[i]) tokens_due.push_back(step_out[i]);
  endtask

  // Stop offering and let every pending token item come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic res_t typed_res(input logic [7:0] c, input logic has, input kind_e k,
                                     input logic beg, input logic cls,
                                     input logic [LINE_NO_W-1:0] line);
    res_t r;
    r.tok_char    = c;
    r.has_char    = has;
    r.token_kind  = k;
    r.begins      = beg;
    r.closes      = cls;
    r.line_no     = line;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] c, input logic eos, input row_check_e chk,
                                  input res_t want);
    dir_row_t r;
    r.ch   = c;
    r.eos  = eos;
    r.chk  = chk;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [7:0] any_letter();
    int unsigned r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] any_alnum();
    int unsigned r;
    r = $urandom_range(0, 61);
    return (r < 10) ? 8'("0" + r) : any_letter();
  endfunction

  function automatic logic [7:0] any_punct();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126));
    while (char_digit(c) || char_letter(c) || c == CH_UNDERSCORE || c == CH_SEMI ||
           c == CH_QUOTE || c == CH_DQUOTE);
    return c;
  endfunction

  function automatic logic [7:0] str_body_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_DQUOTE || c == CH_BSLASH);
    return c;
  endfunction

  // One random source fragment: mostly well formed tokens, some noise
  task automatic gen_fragment();
    int unsigned pick;
    int unsigned n;
    int unsigned r;
    if ($urandom_range(0, 99) < 3) wait_drained();
    if ($urandom_range(0, 99) < 10) tx_gaps = !tx_gaps;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      // identifier
      send_pred(($urandom_range(0, 4) == 0) ? CH_UNDERSCORE : any_letter(), 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) send_pred(($urandom_range(0, 5) == 0) ? CH_UNDERSCORE : any_alnum(), 1'b0);
    end else if (pick < 30) begin
      // number
      send_pred(8'("0" + $urandom_range(0, 9)), 1'b0);
      n = $urandom_range(0, 4);
      repeat (n) send_pred(any_alnum(), 1'b0);
    end else if (pick < 45) begin
      // string literal
      send_pred(CH_DQUOTE, 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          send_pred(CH_BSLASH, 1'b0);
          case ($urandom_range(0, 4))
            0: send_pred(CH_LOW_N, 1'b0);
            1: send_pred(CH_LOW_T, 1'b0);
            2: send_pred(CH_DQUOTE, 1'b0);
            3: send_pred(CH_BSLASH, 1'b0);
            default: send_pred(8'($urandom_range(0, 255)), 1'b0);
          endcase
        end else if (r < 28) begin
          send_pred(CH_NL, 1'b0);
        end else begin
          send_pred(str_body_byte(), 1'b0);
        end
      end
      send_pred(CH_DQUOTE, 1'b0);
    end else if (pick < 55) begin
      // character literal
      send_pred(CH_QUOTE, 1'b0);
      if ($urandom_range(0, 99) < 30) begin
        send_pred(CH_BSLASH, 1'b0);
        case ($urandom_range(0, 3))
          0: send_pred(CH_BSLASH, 1'b0);
          1: send_pred(CH_LOW_T, 1'b0);
          2: send_pred(CH_LOW_N, 1'b0);
          default: send_pred(8'($urandom_range(0, 255)), 1'b0);
        endcase
      end else begin
        send_pred(8'($urandom_range(0, 255)), 1'b0);
      end
      send_pred(($urandom_range(0, 99) < 80) ? CH_QUOTE : 8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 62) begin
      // comment to end of line
      send_pred(CH_SEMI, 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) send_pred(8'($urandom_range(0, 255)) & 8'hF7 | 8'h01, 1'b0);
      send_pred(CH_NL, 1'b0);
    end else if (pick < 72) begin
      send_pred(any_punct(), 1'b0);
    end else if (pick < 84) begin
      case ($urandom_range(0, 2))
        0: send_pred(CH_SPACE, 1'b0);
        1: send_pred(CH_TAB, 1'b0);
        default: send_pred(CH_NL, 1'b0);
      endcase
    end else if (pick < 92) begin
      send_pred(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 97) begin
      // literal cut short by end of source
      case ($urandom_range(0, 3))
        0: begin
          send_pred(CH_DQUOTE, 1'b0);
          n = $urandom_range(0, 3);
          repeat (n) send_pred(str_body_byte(), 1'b0);
          if ($urandom_range(0, 1) == 1) send_pred(CH_BSLASH, 1'b0);
        end
        1: send_pred(CH_QUOTE, 1'b0);
        2: begin
          send_pred(CH_QUOTE, 1'b0);
          send_pred(8'($urandom_range(0, 255)), 1'b0);
        end
        default: begin
          send_pred(CH_QUOTE, 1'b0);
          send_pred(CH_BSLASH, 1'b0);
          send_pred(8'($urandom_range(0, 255)), 1'b0);
        end
      endcase
      send_pred(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_pred(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Output side pacing: short stalls, long stalls, calm stretches, one long hold
  initial begin
    m_axis_tready <= 1'b0;
    hold_seen  = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    calm_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 199;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        m_axis_tready <= 1'b1;
      end else begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 15) begin
          calm_left = $urandom_range(20, 120);
          m_axis_tready <= 1'b1;
        end else if (rx_roll < 70) begin
          m_axis_tready <= 1'b1;
        end else if (rx_roll < 93) begin
          stall_left = $urandom_range(0, 2);
          m_axis_tready <= 1'b0;
        end else begin
          stall_left = $urandom_range(8, 40);
          m_axis_tready <= 1'b0;
        end
      end
    end
  end

  // Compare each delivered token item with the oldest pending one
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.tok_char    = m_axis_tdata[7:0];
      got.line_no     = m_axis_tdata[23:8];
      got.has_char    = m_axis_tuser[0];
      got.token_kind  = kind_e'(m_axis_tuser[2:1]);
      got.begins      = m_axis_tuser[3];
      got.closes      = m_axis_tuser[4];
      got.last_result = m_axis_tlast;
      if (tokens_due.size() == 0) begin
        flag_mismatch($sformatf("item with none pending: char %0d line %0d",
                                got.tok_char, got.line_no));
      end else begin
        want = tokens_due.pop_front();
        if (got.tok_char !== want.tok_char)
          flag_mismatch($sformatf("tok_char %0d, want %0d", got.tok_char, want.tok_char));
        if (got.has_char !== want.has_char)
          flag_mismatch($sformatf("has_char %0b, want %0b", got.has_char, want.has_char));
        if (got.token_kind !== want.token_kind)
          flag_mismatch($sformatf("token_kind %0d, want %0d",
                                  got.token_kind, want.token_kind));
        if (got.begins !== want.begins)
          flag_mismatch($sformatf("begins %0b, want %0b", got.begins, want.begins));
        if (got.closes !== want.closes)
          flag_mismatch($sformatf("closes %0b, want %0b", got.closes, want.closes));
        if (got.line_no !== want.line_no)
          flag_mismatch($sformatf("line_no %0d, want %0d", got.line_no, want.line_no));
        if (got.last_result !== want.last_result)
          flag_mismatch($sformatf("last_result %0b, want %0b",
                                  got.last_result, want.last_result));
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'd0;
    s_axis_tlast  <= 1'b0;
    hold_req      = 1'b0;
    mismatch_cnt  = 0;
    rand_items    = 0;
    tx_gaps       = 1'b1;
    predict_reset();

    // punctuation extremes, ignored bytes, empty string
    add_row("+", 1'b0, ROW_TYPED, typed_res("+", 1'b1, KIND_PUNCT, 1'b1, 1'b1, 16'd1));
    add_row(CH_PRINT_LO, 1'b0, ROW_TYPED,
            typed_res(CH_PRINT_LO, 1'b1, KIND_PUNCT, 1'b1, 1'b1, 16'd1));
    add_row(CH_PRINT_HI, 1'b0, ROW_TYPED,
            typed_res(CH_PRINT_HI, 1'b1, KIND_PUNCT, 1'b1, 1'b1, 16'd1));
    add_row(8'h00, 1'b0, ROW_QUIET, '0);
    add_row(8'hFF, 1'b0, ROW_QUIET, '0);
    add_row(CH_DQUOTE, 1'b0, ROW_QUIET, '0);
    add_row(CH_DQUOTE, 1'b0, ROW_TYPED,
            typed_res(8'd0, 1'b0, KIND_STRING, 1'b1, 1'b1, 16'd1));
    // char literal with the largest code, then one with an unknown escape
    add_row(CH_QUOTE, 1'b0, ROW_MODEL, '0);
    add_row(8'hFF, 1'b0, ROW_MODEL, '0);
    add_row("x", 1'b0, ROW_MODEL, '0);
    add_row(CH_QUOTE, 1'b0, ROW_MODEL, '0);
    add_row(CH_BSLASH, 1'b0, ROW_MODEL, '0);
    add_row("q", 1'b0, ROW_MODEL, '0);
    add_row(".", 1'b0, ROW_MODEL, '0);
    // identifier ended by a comment, newline closes the comment
    add_row(CH_UNDERSCORE, 1'b0, ROW_MODEL, '0);
    add_row("9", 1'b0, ROW_MODEL, '0);
    add_row(CH_SEMI, 1'b0, ROW_MODEL, '0);
    add_row(CH_NL, 1'b0, ROW_MODEL, '0);
    // number closed by end of source
    add_row("7", 1'b0, ROW_MODEL, '0);
    add_row("k", 1'b0, ROW_MODEL, '0);
    add_row(8'hA5, 1'b1, ROW_MODEL, '0);
    // dangling escape in an empty string at end of source
    add_row(CH_DQUOTE, 1'b0, ROW_MODEL, '0);
    add_row(CH_BSLASH, 1'b0, ROW_MODEL, '0);
    add_row(8'h5A, 1'b1, ROW_TYPED, typed_res(8'd0, 1'b0, KIND_STRING, 1'b1, 1'b1, 16'd1));
    // char literal waiting for its closing byte at end of source
    add_row(CH_QUOTE, 1'b0, ROW_MODEL, '0);
    add_row("Z", 1'b0, ROW_MODEL, '0);
    add_row(8'h00, 1'b1, ROW_MODEL, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].ch, dir_rows[i].eos);
      case (dir_rows[i].chk)
        ROW_MODEL: foreach (step_out[j]) tokens_due.push_back(step_out[j]);
        ROW_TYPED: tokens_due.push_back(dir_rows[i].want);
        default: ;
      endcase
    end
    wait_drained();

    // line counting over a run of newlines, back to back
    tx_gaps = 1'b0;
    repeat (6) send_pred(CH_NL, 1'b0);
    send_pred("a", 1'b0);
    send_pred(CH_SPACE, 1'b0);
    send_pred("1", 1'b0);
    send_pred(8'hFF, 1'b1);

    // long receiver hold while punctuation keeps coming
    hold_req = !hold_req;
    repeat (48) send_pred("+", 1'b0);
    wait_drained();

    // random source text up to the item budget
    tx_gaps    = 1'b1;
    while (rand_items < 420) gen_fragment();
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
